// ===== rtl/core/prp_pkg.sv =====
package prp_pkg;

	localparam int NUM_REGS  = 16;
	localparam int REG_W     = 4;
	localparam int PRES_MAX  = 5;
	localparam int PRES_LEN_W = 3;
	localparam int ANY_N     = 7;
	localparam int CALL_N    = 5;

	typedef logic [REG_W-1:0]    reg_num_t;
	typedef logic [NUM_REGS-1:0] reg_mask_t;

	typedef enum logic [2:0] {
		CMD_RESERVE     = 3'd0,
		CMD_HOLD        = 3'd1,
		CMD_TRY_RESERVE = 3'd2,
		CMD_ALLOCATE    = 3'd3,
		CMD_TRY_ALLOC   = 3'd4,
		CMD_RELEASE     = 3'd5,
		CMD_DISCARD     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRY_FAIL  = 2'd1,
		ST_CONFLICT  = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	localparam reg_num_t REG_RBX = 4'd3;
	localparam reg_num_t REG_RSI = 4'd6;
	localparam reg_num_t REG_RDI = 4'd7;
	localparam reg_num_t REG_R8  = 4'd8;
	localparam reg_num_t REG_R9  = 4'd9;
	localparam reg_num_t REG_R12 = 4'd12;
	localparam reg_num_t REG_R13 = 4'd13;
	localparam reg_num_t REG_R14 = 4'd14;
	localparam reg_num_t REG_R15 = 4'd15;

	// allocation priority, general and across-call
	localparam reg_num_t ORDER_ANY [ANY_N] = '{
		REG_R8, REG_R9, REG_RBX, REG_R12, REG_R13, REG_R14, REG_R15
	};
	localparam reg_num_t ORDER_CALL [CALL_N] = '{
		REG_RBX, REG_R12, REG_R13, REG_R14, REG_R15
	};

	// one update of the preserve list
	typedef struct packed {
		logic     add;
		logic     drop;
		reg_num_t num;
	} pres_op_t;

	// result of the priority pick
	typedef struct packed {
		logic     found;
		reg_num_t num;
	} pick_t;

	function automatic logic callee_saved(reg_num_t r);
		return (r == REG_RBX) || (r == REG_R12) || (r == REG_R13) ||
			(r == REG_R14) || (r == REG_R15);
	endfunction

	function automatic logic freeable(reg_num_t r);
		return (r == REG_RSI) || (r == REG_RDI) || (r == REG_R8) ||
			(r == REG_R9) || callee_saved(r);
	endfunction

endpackage

// ===== rtl/core/prp_if.sv =====
interface prp_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [3:0] reg_in;
	logic       spans_call;

	modport source (output valid, cmd, reg_in, spans_call, input ready);
	modport sink   (input valid, cmd, reg_in, spans_call, output ready);
endinterface

interface prp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  reg_out;
	logic [15:0] used_mask;
	logic [15:0] held_mask;
	logic [2:0]  preserve_count;
	logic [19:0] preserve_list;

	modport source (output valid, status, reg_out, used_mask, held_mask,
		preserve_count, preserve_list, input ready);
	modport sink   (input valid, status, reg_out, used_mask, held_mask,
		preserve_count, preserve_list, output ready);
endinterface

// ===== rtl/core/prp_pick.sv =====
module prp_pick (
	input  prp_pkg::reg_mask_t used,
	input  prp_pkg::reg_mask_t held,
	input  logic               spans_call,
	output prp_pkg::pick_t     pick
);
	import prp_pkg::*;

	logic found_free;
	logic found_any;
	reg_num_t num_free;
	reg_num_t num_any;

	// scan priority order back to front so the first candidate wins
	always_comb begin
		found_free = 1'b0;
		found_any  = 1'b0;
		num_free   = '0;
		num_any    = '0;
		if (spans_call) begin
			for (int i = CALL_N - 1; i >= 0; i--) begin
				if (!used[ORDER_CALL[i]]) begin
					found_any = 1'b1;
					num_any   = ORDER_CALL[i];
					if (!held[ORDER_CALL[i]]) begin
						found_free = 1'b1;
						num_free   = ORDER_CALL[i];
					end
				end
			end
		end else begin
			for (int i = ANY_N - 1; i >= 0; i--) begin
				if (!used[ORDER_ANY[i]]) begin
					found_any = 1'b1;
					num_any   = ORDER_ANY[i];
					if (!held[ORDER_ANY[i]]) begin
						found_free = 1'b1;
						num_free   = ORDER_ANY[i];
					end
				end
			end
		end
	end

	// prefer an unheld register, fall back to a held one
	assign pick.found = found_any;
	assign pick.num   = found_free ? num_free : num_any;

endmodule

// ===== rtl/core/prp_preserve.sv =====
module prp_preserve (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  prp_pkg::pres_op_t                  op,
	output logic [prp_pkg::PRES_LEN_W-1:0]     len_next,
	output logic [prp_pkg::PRES_MAX*prp_pkg::REG_W-1:0] list_next
);
	import prp_pkg::*;

	reg_num_t              ent_q [PRES_MAX];
	logic [PRES_LEN_W-1:0] len_q;
	reg_num_t              ent_d [PRES_MAX];
	logic [PRES_MAX-1:0]   hit;
	logic                  found;

	// find the register among the live entries
	always_comb begin
		for (int i = 0; i < PRES_MAX; i++) begin
			hit[i] = (PRES_LEN_W'(i) < len_q) && (ent_q[i] == op.num);
		end
	end
	assign found = |hit;

	// append on first reserve, close the gap on drop
	always_comb begin
		logic shift;
		shift    = 1'b0;
		ent_d    = ent_q;
		len_next = len_q;
		if (en && op.add && !found && (len_q < PRES_LEN_W'(PRES_MAX))) begin
			for (int i = 0; i < PRES_MAX; i++) begin
				if (len_q == PRES_LEN_W'(i)) begin
					ent_d[i] = op.num;
				end
			end
			len_next = len_q + PRES_LEN_W'(1);
		end else if (en && op.drop && found) begin
			for (int i = 0; i < PRES_MAX - 1; i++) begin
				shift = shift | hit[i];
				if (shift) begin
					ent_d[i] = ent_q[i+1];
				end
			end
			len_next = len_q - PRES_LEN_W'(1);
		end
	end

	// pack live entries, zero the rest
	always_comb begin
		for (int i = 0; i < PRES_MAX; i++) begin
			list_next[i*REG_W +: REG_W] = (PRES_LEN_W'(i) < len_next) ? ent_d[i] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (en) begin
			len_q <= len_next;
		end
	end

	// entries carry no reset: only those below the length are read
	always_ff @(posedge clk) begin
		if (en) begin
			ent_q <= ent_d;
		end
	end

endmodule

// ===== rtl/core/priority_register_pool.sv =====
// Channel  Role  Beat fields
// -------  ----  ------------------------------------------------------------
// req      sink  cmd, reg_in, spans_call
// rsp      src   status, reg_out, used_mask, held_mask, preserve_count,
//               preserve_list
//
// One command per cycle sustained while rsp takes beats; from accept, each
// goes through an input register, then the pick and state update, then the
// result register. Pool state changes at the edge the result is loaded.
// Reset clears used, hold, counts and the preserve length; preserve entries
// are left as they are. When rsp stalls, a waiting command holds in the
// input register and req drops ready until the result beat moves on.
module priority_register_pool #(
	parameter int COUNT_BITS = 8
) (
	input logic    clk,
	input logic    arst_n,
	prp_req_if.sink   req,
	prp_rsp_if.source rsp
);
	import prp_pkg::*;

	// input register
	logic     valid_s1;
	cmd_t     cmd_s1;
	reg_num_t reg_s1;
	logic     across_s1;

	// pool state
	reg_mask_t             used_q;
	reg_mask_t             held_q;
	logic [COUNT_BITS-1:0] cnt_q [NUM_REGS];

	logic      advance;
	pick_t     pick;
	logic      take;
	reg_num_t  take_num;
	reg_mask_t used_d;
	reg_mask_t held_d;
	status_t   status_d;
	reg_num_t  reg_out_d;
	logic      drop;
	logic [NUM_REGS-1:0] cnt_one;
	pres_op_t  pres_op;
	logic [PRES_LEN_W-1:0]     pres_len_d;
	logic [PRES_MAX*REG_W-1:0] pres_list_d;

	assign advance   = valid_s1 && (!rsp.valid || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// hold a beat until it can move into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1    <= cmd_t'(req.cmd);
			reg_s1    <= req.reg_in;
			across_s1 <= req.spans_call;
		end
	end

	prp_pick u_pick (
		.used       (used_q),
		.held       (held_q),
		.spans_call (across_s1),
		.pick       (pick)
	);

	// per-register flag: count is exactly one
	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			cnt_one[r] = (cnt_q[r] == COUNT_BITS'(1));
		end
	end

	// decode the command against current state
	always_comb begin
		take      = 1'b0;
		take_num  = reg_s1;
		drop      = 1'b0;
		status_d  = ST_OK;
		reg_out_d = reg_s1;
		used_d    = used_q;
		held_d    = held_q;
		case (cmd_s1)
			CMD_RESERVE: begin
				if (used_q[reg_s1]) status_d = ST_CONFLICT;
				else take = 1'b1;
			end
			CMD_HOLD: begin
				held_d[reg_s1] = 1'b1;
			end
			CMD_TRY_RESERVE: begin
				if (used_q[reg_s1]) status_d = ST_TRY_FAIL;
				else take = 1'b1;
			end
			CMD_ALLOCATE, CMD_TRY_ALLOC: begin
				if (pick.found) begin
					take      = 1'b1;
					take_num  = pick.num;
					reg_out_d = pick.num;
				end else begin
					status_d = (cmd_s1 == CMD_ALLOCATE) ? ST_EXHAUSTED : ST_TRY_FAIL;
				end
			end
			CMD_RELEASE: begin
				if (freeable(reg_s1)) used_d[reg_s1] = 1'b0;
			end
			CMD_DISCARD: begin
				if (freeable(reg_s1)) used_d[reg_s1] = 1'b0;
				drop = callee_saved(reg_s1) && cnt_one[reg_s1];
			end
			default: begin
			end
		endcase
		if (take) begin
			used_d[take_num] = 1'b1;
			held_d[take_num] = 1'b0;
		end
	end

	assign pres_op.add  = take && callee_saved(take_num);
	assign pres_op.drop = drop;
	assign pres_op.num  = take_num;

	prp_preserve u_preserve (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.op        (pres_op),
		.len_next  (pres_len_d),
		.list_next (pres_list_d)
	);

	// advance pool state with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			held_q <= '0;
			for (int r = 0; r < NUM_REGS; r++) begin
				cnt_q[r] <= '0;
			end
		end else if (advance) begin
			used_q <= used_d;
			held_q <= held_d;
			for (int r = 0; r < NUM_REGS; r++) begin
				if (take && (take_num == REG_W'(r)) && (cnt_q[r] != '1)) begin
					cnt_q[r] <= cnt_q[r] + COUNT_BITS'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (advance) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.status         <= status_d;
			rsp.reg_out        <= reg_out_d;
			rsp.used_mask      <= used_d;
			rsp.held_mask      <= held_d;
			rsp.preserve_count <= pres_len_d;
			rsp.preserve_list  <= pres_list_d;
		end
	end

endmodule
